[rtl/core/sccw_pkg.sv]
// shared types and constants for the scaled crop window clipper
// no dependencies; used by sccw_axis and the top level
package sccw_pkg;

  localparam int CW = 16;

  typedef enum logic [1:0] {
    CFG_VIS_X = 2'd0,
    CFG_VIS_Y = 2'd1,
    CFG_VIS_W = 2'd2,
    CFG_VIS_H = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] crop_x;
    logic signed [CW-1:0] crop_y;
    logic signed [CW-1:0] crop_w;
    logic signed [CW-1:0] crop_h;
    logic signed [CW-1:0] win_x;
    logic signed [CW-1:0] win_y;
    logic signed [CW-1:0] win_w;
    logic signed [CW-1:0] win_h;
    logic [1:0]           rotation;
    logic                 mirror;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] out_crop_x;
    logic signed [CW-1:0] out_crop_y;
    logic signed [CW-1:0] out_crop_w;
    logic signed [CW-1:0] out_crop_h;
    logic signed [CW-1:0] out_win_x;
    logic signed [CW-1:0] out_win_y;
    logic signed [CW-1:0] out_win_w;
    logic signed [CW-1:0] out_win_h;
    logic                 status;
  } res_t;

  // one display axis worth of work: crop axis k, window and visible span
  typedef struct packed {
    logic                 k;
    logic                 flip;
    logic signed [CW-1:0] pos;
    logic signed [CW-1:0] size;
    logic signed [CW-1:0] wpos;
    logic signed [CW-1:0] wsize;
    logic signed [CW-1:0] vpos;
    logic [CW-2:0]        vsize;
  } axis_req_t;

  typedef struct packed {
    logic          k;
    logic          rej;
    logic [CW-1:0] cpos;
    logic [CW-1:0] csize;
    logic [CW-1:0] wpos;
    logic [CW-1:0] wsize;
  } axis_res_t;

endpackage

[rtl/core/sccw_div.sv]
// pipelined unsigned restoring divider, one quotient bit per stage
// quotient must fit QW bits (num < den << QW); no package dependency
module sccw_div #(
  parameter int NW = 30,
  parameter int DW = 15,
  parameter int QW = 15,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic          vld [QW];
  logic [NW-1:0] rem [QW-1];
  logic [DW-1:0] dv  [QW];
  logic [QW-1:0] q   [QW];
  logic [SW-1:0] sd  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] sd_in;
    logic [NW-1:0] shifted;
    logic          fits;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign sd_in  = side;
    end else begin : g_next
      assign v_in   = vld[i-1];
      assign rem_in = rem[i-1];
      assign den_in = dv[i-1];
      assign q_in   = q[i-1];
      assign sd_in  = sd[i-1];
    end

    assign shifted = NW'(den_in) << (QW - 1 - i);
    assign fits    = rem_in >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dv[i] <= den_in;
      q[i]  <= q_in | (QW'(fits) << (QW - 1 - i));
      sd[i] <= sd_in;
    end

    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[i] <= fits ? rem_in - shifted : rem_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = q[QW-1];
  assign out_side  = sd[QW-1];

endmodule

[rtl/core/sccw_axis.sv]
// clips one display axis: reject test, left trim and right scale of the crop
// depends on sccw_pkg and two sccw_div instances
module sccw_axis (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sccw_pkg::axis_req_t req,
  output logic                out_valid,
  output sccw_pkg::axis_res_t res
);
  import sccw_pkg::*;

  localparam int XW = CW + 2;
  localparam int NW = 2 * CW - 2;
  localparam int QW = CW - 1;

  typedef struct packed {
    logic          k;
    logic          flip;
    logic          rej;
    logic          right;
    logic          sign;
    logic [CW-1:0] mag;
    logic [CW-1:0] pos;
    logic [CW-2:0] e;
    logic [CW-1:0] wp1;
    logic [CW-2:0] ws0;
    logic [CW-2:0] ws1;
  } side_t;

  localparam int SW = $bits(side_t);

  // stage 1 logic
  logic signed [XW-1:0] wp_e, ws_e, vp_e, vs_e, vend, wend, dd, wp1_e, ws1_e, e_e;
  logic signed [CW:0]   s_ext, s_or, mag_full;
  logic                 left;
  side_t                s1_next;
  logic [CW-2:0]        d1_next;

  logic          v1, v2, v3, v4, v5, v3i;
  side_t         s1, s2, s3, s4, s3i, s5, s3_next;
  logic [CW-2:0] d1;
  logic [NW-1:0] num2, num4;
  logic [QW-1:0] q1, q2;
  logic [2*CW-2:0] prod1, prod2;
  logic [SW-1:0] s3i_raw, s5_raw;
  logic [CW-1:0] mag2, ssz;

  always_comb begin
    wp_e  = XW'(req.wpos);
    ws_e  = XW'(req.wsize);
    vp_e  = XW'(req.vpos);
    vs_e  = XW'({1'b0, req.vsize});
    vend  = vp_e + vs_e;
    wend  = wp_e + ws_e;
    left  = wp_e < vp_e;
    dd    = left ? vp_e - wp_e : '0;
    wp1_e = left ? vp_e : wp_e;
    ws1_e = ws_e - dd;
    e_e   = vend - wp1_e;
    s_ext = (CW+1)'(req.size);
    s_or  = req.flip ? -s_ext : s_ext;
    mag_full = s_or[CW] ? -s_or : s_or;

    s1_next.k     = req.k;
    s1_next.flip  = req.flip;
    s1_next.rej   = !(ws_e > 0) || (req.vsize == '0) || (wend <= vp_e) ||
                    (wp_e >= vend) || (req.size == '0);
    s1_next.right = wend > vend;
    s1_next.sign  = s_or[CW];
    s1_next.mag   = mag_full[CW-1:0];
    s1_next.pos   = req.flip ? req.pos + req.size : req.pos;
    s1_next.e     = e_e[CW-2:0];
    s1_next.wp1   = wp1_e[CW-1:0];
    s1_next.ws0   = ws_e[CW-2:0];
    s1_next.ws1   = ws1_e[CW-2:0];
    d1_next       = dd[CW-2:0];
  end

  assign prod1 = d1 * s1.mag;
  assign prod2 = s3.mag * s3.e;

  // left trim applied: size shrinks by the quotient, position moves with sign
  always_comb begin
    s3_next     = s3i;
    s3_next.mag = s3i.mag - CW'(q1);
    s3_next.pos = s3i.sign ? s3i.pos - CW'(q1) : s3i.pos + CW'(q1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v3i;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s1   <= s1_next;
    d1   <= d1_next;
    s2   <= s1;
    num2 <= prod1[NW-1:0];
    s3   <= s3_next;
    s4   <= s3;
    num4 <= prod2[NW-1:0];
  end

  // trim divides by the window size before the trim
  sccw_div #(.NW(NW), .DW(CW-1), .QW(QW), .SW(SW)) u_div_trim (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .num       (num2),
    .den       (s2.ws0),
    .side      (s2),
    .out_valid (v3i),
    .quo       (q1),
    .out_side  (s3i_raw)
  );
  assign s3i = side_t'(s3i_raw);

  sccw_div #(.NW(NW), .DW(CW-1), .QW(QW), .SW(SW)) u_div_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .num       (num4),
    .den       (s4.ws1),
    .side      (s4),
    .out_valid (v5),
    .quo       (q2),
    .out_side  (s5_raw)
  );
  assign s5 = side_t'(s5_raw);

  always_comb begin
    mag2 = s5.right ? {1'b0, q2} : s5.mag;
    ssz  = s5.sign ? -mag2 : mag2;
    res.k     = s5.k;
    res.rej   = s5.rej || (mag2 == '0);
    res.cpos  = s5.flip ? s5.pos + ssz : s5.pos;
    res.csize = s5.flip ? -ssz : ssz;
    res.wpos  = s5.wp1;
    res.wsize = s5.right ? {1'b0, s5.e} : {1'b0, s5.ws1};
  end

  assign out_valid = v5;

endmodule

[rtl/core/scaled_crop_window_clipper_unit.sv]
// a result strobes on done once a taken start has passed the input register, the axis pipelines and done
// throughput: one request per cycle while busy is low; two 15-stage divider pipelines per axis set the depth
// busy is high only during reset; results cannot be held off by the receiver
// reset (rst, synchronous) clears the pipeline valid bits and the visible area to zero
// depends on sccw_pkg and sccw_axis
module scaled_crop_window_clipper_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  sccw_pkg::req_t         req,
  input  logic                   cfg_we,
  input  sccw_pkg::cfg_idx_t     cfg_idx,
  input  logic [sccw_pkg::CW-1:0] cfg_data,
  output logic                   done,
  output sccw_pkg::res_t         result
);
  import sccw_pkg::*;

  logic signed [CW-1:0] vis_x, vis_y;
  logic [CW-2:0]        vis_w, vis_h;

  logic      v0;
  req_t      rq;
  logic      swp, r2, flip0, flip1;
  axis_req_t ax_req [2];
  axis_res_t ax_res [2];
  logic      ax_v [2];
  axis_res_t cx, cy;
  logic      rej;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vis_x <= '0;
      vis_y <= '0;
      vis_w <= '0;
      vis_h <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_VIS_X: vis_x <= cfg_data;
        CFG_VIS_Y: vis_y <= cfg_data;
        CFG_VIS_W: vis_w <= cfg_data[CW-2:0];
        CFG_VIS_H: vis_h <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    rq <= req;
  end

  // net edge flips per crop axis; the same flips map back afterwards
  always_comb begin
    swp   = rq.rotation[0];
    r2    = rq.rotation[1];
    flip0 = swp ? r2 : (rq.mirror ^ r2);
    flip1 = swp ? !(rq.mirror ^ r2) : r2;

    ax_req[0].k     = swp;
    ax_req[0].flip  = swp ? flip1 : flip0;
    ax_req[0].pos   = swp ? rq.crop_y : rq.crop_x;
    ax_req[0].size  = swp ? rq.crop_h : rq.crop_w;
    ax_req[0].wpos  = rq.win_x;
    ax_req[0].wsize = rq.win_w;
    ax_req[0].vpos  = vis_x;
    ax_req[0].vsize = vis_w;

    ax_req[1].k     = !swp;
    ax_req[1].flip  = swp ? flip0 : flip1;
    ax_req[1].pos   = swp ? rq.crop_x : rq.crop_y;
    ax_req[1].size  = swp ? rq.crop_w : rq.crop_h;
    ax_req[1].wpos  = rq.win_y;
    ax_req[1].wsize = rq.win_h;
    ax_req[1].vpos  = vis_y;
    ax_req[1].vsize = vis_h;
  end

  for (genvar c = 0; c < 2; c++) begin : g_axis
    sccw_axis u_axis (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v0),
      .req       (ax_req[c]),
      .out_valid (ax_v[c]),
      .res       (ax_res[c])
    );
  end

  always_comb begin
    cx  = (ax_res[0].k == 1'b0) ? ax_res[0] : ax_res[1];
    cy  = (ax_res[1].k == 1'b1) ? ax_res[1] : ax_res[0];
    rej = ax_res[0].rej || ax_res[1].rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ax_v[0] && ax_v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rej) begin
      result.out_crop_x <= '0;
      result.out_crop_y <= '0;
      result.out_crop_w <= '0;
      result.out_crop_h <= '0;
      result.out_win_x  <= '0;
      result.out_win_y  <= '0;
      result.out_win_w  <= '0;
      result.out_win_h  <= '0;
      result.status     <= 1'b1;
    end else begin
      result.out_crop_x <= cx.cpos;
      result.out_crop_y <= cy.cpos;
      result.out_crop_w <= cx.csize;
      result.out_crop_h <= cy.csize;
      result.out_win_x  <= ax_res[0].wpos;
      result.out_win_y  <= ax_res[1].wpos;
      result.out_win_w  <= ax_res[0].wsize;
      result.out_win_h  <= ax_res[1].wsize;
      result.status     <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2 * CW + 4))
    else $error("result strobe without a matching request");

  a_visible_win: assert property (@(posedge clk) disable iff (rst)
    done && !result.status |->
      !result.out_win_w[CW-1] && result.out_win_w != '0 &&
      !result.out_win_h[CW-1] && result.out_win_h != '0)
    else $error("visible result with an empty window");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status |->
      result.out_crop_w == '0 && result.out_crop_h == '0 &&
      result.out_win_w == '0 && result.out_win_h == '0)
    else $error("rejected result carries a rectangle");
`endif

endmodule
